>>> hw/rtl/min_max_partition_sum_macros.svh
// ============================================================================
// min_max_partition_sum_macros: assertion macros for the partition-sum block.
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis. The enclosing module must provide clk and rst_n.
// ============================================================================
`ifndef MIN_MAX_PARTITION_SUM_MACROS_SVH
`define MIN_MAX_PARTITION_SUM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, ignored while reset is asserted.
`define MMPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_max_partition_sum: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define MMPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_max_partition_sum: next-cycle check failed");

`else

`define MMPS_ASSERT_SAME(label, ante, cons)
`define MMPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/mmps_pkg.sv
// ============================================================================
// mmps_pkg
// Types and constants shared by the partition-sum block and its interfaces.
// ============================================================================
`default_nettype none

package mmps_pkg;

    // Field widths fixed by the block's interface.
    localparam int ELEM_BITS   = 32;
    localparam int RESULT_BITS = 42;
    localparam int PART_BITS   = 11;

    // Reset value of the piece-count register.
    localparam logic [PART_BITS-1:0] PART_RESET = PART_BITS'(1);

    // Defaults for the top-level parameters.
    localparam int MAX_ELEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Sums are capped at this many bits; wider sums wrap.
    localparam int SUM_CAP_BITS = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_MID,
        S_PASS,
        S_DECIDE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mmps_in_if.sv
// ============================================================================
// mmps_in_if
// Valid/ready channel that carries one array element per beat.
// ============================================================================
`default_nettype none

interface mmps_in_if;
    import mmps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] element_value;
    logic                 last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mmps_out_if.sv
// ============================================================================
// mmps_out_if
// Valid/ready channel that carries one search result per beat.
// ============================================================================
`default_nettype none

interface mmps_out_if;
    import mmps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [RESULT_BITS-1:0] min_largest_sum;
    logic                   overflow;

    modport source (output valid, output min_largest_sum, output overflow, input ready);
    modport sink   (input valid, input min_largest_sum, input overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mmps_ram.sv
// ============================================================================
// mmps_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module mmps_ram #(
    parameter int  WIDTH     = 32,
    parameter int  DEPTH     = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/min_max_partition_sum.sv
// ============================================================================
// min_max_partition_sum
// Takes an array of unsigned values, one element per input beat, and returns
// the smallest bound B such that the array splits into at most part_count
// contiguous pieces whose sums are all no greater than B. Elements are written
// to an on-chip store while the largest element and the total are tracked;
// the beat marked last_element starts a binary search for B between those
// two values. Each probe is a greedy pass over the store through one shared
// adder and comparator, reading one element per cycle from a single RAM read
// port. The number of probes is at most the bit width of the total, 42 with
// the default parameters; the input is not ready during the search. Elements
// beyond MAX_ELEMS are dropped and reported through the overflow flag. A
// part_count of zero yields a bound of zero. The result sits in an output
// register, so loading of the next array may begin while it waits to be
// taken. No clearing pass is needed after reset.
// ============================================================================
`default_nettype none

`include "min_max_partition_sum_macros.svh"

module min_max_partition_sum #(
    parameter int MAX_ELEMS  = mmps_pkg::MAX_ELEMS_DEF,
    parameter int VALUE_BITS = mmps_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mmps_pkg::PART_BITS-1:0] cfg_wdata,
    mmps_in_if.sink                             items,
    mmps_out_if.source                          results
);

    import mmps_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    // Element bits actually kept: the input field is masked to VALUE_BITS.
    localparam int EW      = (VALUE_BITS < ELEM_BITS) ? VALUE_BITS : ELEM_BITS;
    // Store address and element count (the count must be able to hold MAX_ELEMS).
    localparam int AW      = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW      = $clog2(MAX_ELEMS + 1);
    // The total of MAX_ELEMS elements fits EW + log2(MAX_ELEMS) bits; beyond
    // 64 bits the sums wrap.
    localparam int SW_FULL = EW + $clog2(MAX_ELEMS);
    localparam int SW      = (SW_FULL > SUM_CAP_BITS) ? SUM_CAP_BITS : SW_FULL;
    // A greedy pass can open at most one piece per element plus the first.
    localparam int PW      = $clog2(MAX_ELEMS + 2);
    localparam int CMPW    = (PW > PART_BITS) ? PW : PART_BITS;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [PART_BITS-1:0]   part_count_reg;

    // During loading low_reg tracks the largest element and high_reg the
    // total; during the search they are the bounds of the search interval.
    logic [CW-1:0]          count_reg, count_next;
    logic [SW-1:0]          low_reg, low_next;
    logic [SW-1:0]          high_reg, high_next;
    logic                   ovf_reg, ovf_next;

    // Search scratch.
    logic [SW-1:0]          diff_reg, diff_next;
    logic [SW-1:0]          probe_reg, probe_next;
    logic [SW-1:0]          running_reg, running_next;
    logic [PW-1:0]          pieces_reg, pieces_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   rd_vld_reg, rd_vld_next;

    // Output holding register.
    logic                   out_valid_reg, out_valid_next;
    logic [RESULT_BITS-1:0] out_sum_reg, out_sum_next;
    logic                   out_ovf_reg, out_ovf_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic                   in_accept;
    logic                   store_full;
    logic [EW-1:0]          elem_in;
    logic                   issue;
    logic                   pass_over;
    logic                   result_load;
    logic                   ram_we;
    logic [EW-1:0]          ram_rdata;
    logic [SW-1:0]          sum_try;
    logic                   probe_fits;

    assign elem_in    = items.element_value[EW-1:0];
    assign store_full = (count_reg == CW'(MAX_ELEMS));
    assign in_accept  = items.valid && items.ready;
    assign issue      = (rd_idx_reg < count_reg);
    assign pass_over  = !issue && !rd_vld_reg;
    assign sum_try    = running_reg + SW'(ram_rdata);
    assign probe_fits = (CMPW'(pieces_reg) <= CMPW'(part_count_reg));
    // The result register is free when it is empty or being emptied now.
    assign result_load = (state_reg == S_DONE) && (!out_valid_reg || results.ready);

    // ------------------------------------------------------------------------
    // Element store
    // ------------------------------------------------------------------------
    mmps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (elem_in),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept && items.last_element)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // A zero piece count or a closed interval ends the search.
                if ((part_count_reg == '0) || !(low_reg < high_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                state_next = S_PASS;
            end
            S_PASS:
            begin
                if (pass_over)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                if (result_load)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        items.ready = (state_reg == S_LOAD);
        ram_we      = in_accept && !store_full;
    end

    // ------------------------------------------------------------------------
    // Datapath: loading, probe set-up, greedy pass and interval update
    // ------------------------------------------------------------------------
    always_comb
    begin
        count_next   = count_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        ovf_next     = ovf_reg;
        diff_next    = diff_reg;
        probe_next   = probe_reg;
        running_next = running_reg;
        pieces_next  = pieces_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = rd_vld_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        high_next  = high_reg + SW'(elem_in);
                        if (SW'(elem_in) > low_reg)
                        begin
                            low_next = SW'(elem_in);
                        end
                    end
                end
            end
            S_CHECK:
            begin
                diff_next = high_reg - low_reg;
            end
            S_MID:
            begin
                // Midpoint rounds down, so the probe stays below the upper bound.
                probe_next   = low_reg + (diff_reg >> 1);
                running_next = '0;
                pieces_next  = PW'(1);
                rd_idx_next  = '0;
                rd_vld_next  = 1'b0;
            end
            S_PASS:
            begin
                // Reads are issued in the cycle before the element they return arrives.
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                rd_vld_next = issue;
                if (rd_vld_reg)
                begin
                    if (sum_try > probe_reg)
                    begin
                        running_next = SW'(ram_rdata);
                        pieces_next  = pieces_reg + PW'(1);
                    end
                    else
                    begin
                        running_next = sum_try;
                    end
                end
            end
            S_DECIDE:
            begin
                if (probe_fits)
                begin
                    high_next = probe_reg;
                end
                else
                begin
                    low_next = probe_reg + SW'(1);
                end
            end
            S_DONE:
            begin
                // The array is cleared once its result is loaded into the result register.
                if (result_load)
                begin
                    count_next = '0;
                    low_next   = '0;
                    high_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        out_ovf_next   = out_ovf_reg;
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (result_load)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = (part_count_reg == '0) ? '0 : RESULT_BITS'(low_reg);
            out_ovf_next   = ovf_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.min_largest_sum = out_sum_reg;
    assign results.overflow        = out_ovf_reg;

    // ------------------------------------------------------------------------
    // Flip-flops
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            part_count_reg <= PART_RESET;
            count_reg      <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            ovf_reg        <= 1'b0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            ovf_reg       <= ovf_next;
            rd_idx_reg    <= rd_idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                part_count_reg <= cfg_wdata;
            end
        end
    end

    // Search scratch and result payload need no reset.
    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next;
        probe_reg   <= probe_next;
        running_reg <= running_next;
        pieces_reg  <= pieces_next;
        out_sum_reg <= out_sum_next;
        out_ovf_reg <= out_ovf_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A probe always lies inside the half-open search interval.
    `MMPS_ASSERT_SAME(a_probe_in_range, state_reg == S_DECIDE,
                      (probe_reg >= low_reg) && (probe_reg < high_reg))
    // A greedy pass only finishes after every stored element was read.
    `MMPS_ASSERT_SAME(a_pass_complete, state_reg == S_DECIDE, rd_idx_reg == count_reg)
    // A pass always opens at least one piece.
    `MMPS_ASSERT_SAME(a_pieces_nonzero, state_reg == S_DECIDE, pieces_reg != '0)
    // A finished search waits while the previous result is still held.
    `MMPS_ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && results.valid && !results.ready,
                      state_reg == S_DONE)

endmodule

`default_nettype wire
